FILE: hw/rtl/sensor_word_crc_framer_macros.svh
// Assertion helpers for the CRC word framer.
`ifndef SENSOR_WORD_CRC_FRAMER_MACROS_SVH
`define SENSOR_WORD_CRC_FRAMER_MACROS_SVH

// same-cycle implication, checked outside reset
`define SFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define SFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/sfr_pkg.sv
package sfr_pkg;

  localparam logic [1:0] MODE_CMD      = 2'd0;
  localparam logic [1:0] MODE_CMD_DATA = 2'd1;
  localparam logic [1:0] MODE_RX       = 2'd2;

  localparam logic [7:0]  CRC_INIT   = 8'hFF;
  localparam logic [7:0]  CRC_POLY   = 8'h31;
  localparam logic [15:0] READY_MASK = 16'h07FF;

  // job queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] command;
    logic [15:0] data_word;
    logic [7:0]  rx_byte;
    logic        rx_last;
  } in_item_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        word_valid;
    logic [15:0] word_value;
    logic [2:0]  word_index;
    logic        crc_ok;
    logic        ready_bits_set;
    logic        last;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_CMD      = 2'b00,
    OP_CMD_DATA = 2'b01,
    OP_WORD     = 2'b10
  } op_t;

  // one classified job; for a received word, word_hi holds the word
  typedef struct packed {
    op_t         op;
    logic [15:0] word_hi;
    logic [15:0] word_lo;
    logic [2:0]  idx;
    logic        crc_ok;
    logic        ready;
  } job_t;

  // CRC-8 update with one byte, MSB first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] c;
    c = crc_in ^ data;
    for (int b = 0; b < 8; b++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/sensor_word_crc_framer.sv
// When idle, the first result of an item passes from the job queue through the current-job
// register to the output register before it is presented.
// One result per cycle from the output stage while out_stall is low; a command gives three
// results, a command with data five, and received bytes give a word every third byte.
// A 2-entry job queue lets input keep flowing while a burst is being sent.
// Reset (rst_n low, synchronous): queue empty, no result pending, grouping at start.
`include "sensor_word_crc_framer_macros.svh"

module sensor_word_crc_framer #(
  parameter int MAX_RESPONSE_WORDS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sfr_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output sfr_pkg::out_item_t out_data
);

  localparam int CapInt = (MAX_RESPONSE_WORDS - 1 > 7) ? 7 : MAX_RESPONSE_WORDS - 1;
  localparam logic [2:0] IDX_CAP = 3'(CapInt);

  logic          q_push, q_pop, q_full, q_empty;
  sfr_pkg::job_t q_din, q_dout;
  logic          out_fire, tx_more, word_out;

  sfr_front #(
    .MAX_RESPONSE_WORDS(MAX_RESPONSE_WORDS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data (in_data),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_din   (q_din)
  );

  sfr_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .din  (q_din),
    .full (q_full),
    .pop  (q_pop),
    .empty(q_empty),
    .dout (q_dout)
  );

  sfr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_dout   (q_dout),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  assign out_fire = out_valid && !out_stall;
  assign tx_more  = out_fire && out_data.tx_valid && !out_data.last;
  assign word_out = out_valid && out_data.word_valid;

  // a transmit burst is never broken up once its first byte transfers
  `SFR_ASSERT_NEXT(a_burst_cont, tx_more, out_valid && out_data.tx_valid, "burst interrupted")
  `SFR_ASSERT_NOW(a_word_single, word_out, out_data.last && !out_data.tx_valid, "bad word result")
  `SFR_ASSERT_NOW(a_idx_cap, word_out, out_data.word_index <= IDX_CAP, "word index above cap")
  `SFR_ASSERT_NOW(a_no_pop_empty, q_pop, !q_empty, "job queue popped while empty")

endmodule

FILE: hw/rtl/sfr_front.sv
module sfr_front #(
  parameter int MAX_RESPONSE_WORDS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  sfr_pkg::in_item_t in_data,
  input  logic             q_full,
  output logic             q_push,
  output sfr_pkg::job_t    q_din
);

  localparam int CapInt = (MAX_RESPONSE_WORDS - 1 > 7) ? 7 : MAX_RESPONSE_WORDS - 1;
  localparam logic [2:0] IDX_CAP = 3'(CapInt);

  logic [1:0] pos_r, pos_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [7:0] held_hi_r, held_hi_nxt;
  logic [7:0] held_lo_r, held_lo_nxt;
  logic [7:0] crc_r, crc_nxt;   // running CRC over the bytes held so far
  logic       accept;
  logic [15:0] word;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign word     = {held_hi_r, held_lo_r};

  always_comb begin
    pos_nxt     = pos_r;
    cnt_nxt     = cnt_r;
    held_hi_nxt = held_hi_r;
    held_lo_nxt = held_lo_r;
    crc_nxt     = crc_r;
    q_push      = 1'b0;
    q_din.op      = sfr_pkg::OP_CMD;
    q_din.word_hi = in_data.command;
    q_din.word_lo = in_data.data_word;
    q_din.idx     = cnt_r;
    q_din.crc_ok  = 1'b0;
    q_din.ready   = 1'b0;
    if (accept) begin
      case (in_data.mode)
        sfr_pkg::MODE_CMD, sfr_pkg::MODE_CMD_DATA: begin
          q_push   = 1'b1;
          q_din.op = (in_data.mode == sfr_pkg::MODE_CMD) ? sfr_pkg::OP_CMD
                                                         : sfr_pkg::OP_CMD_DATA;
          pos_nxt  = 2'd0;
          cnt_nxt  = 3'd0;
        end
        sfr_pkg::MODE_RX: begin
          case (pos_r)
            2'd0: begin
              held_hi_nxt = in_data.rx_byte;
              crc_nxt     = sfr_pkg::crc8_byte(sfr_pkg::CRC_INIT, in_data.rx_byte);
              pos_nxt     = 2'd1;
            end
            2'd1: begin
              held_lo_nxt = in_data.rx_byte;
              crc_nxt     = sfr_pkg::crc8_byte(crc_r, in_data.rx_byte);
              pos_nxt     = 2'd2;
            end
            default: begin
              q_push        = 1'b1;
              q_din.op      = sfr_pkg::OP_WORD;
              q_din.word_hi = word;
              q_din.crc_ok  = (crc_r == in_data.rx_byte);
              q_din.ready   = |(word & sfr_pkg::READY_MASK);
              pos_nxt       = 2'd0;
              cnt_nxt       = (cnt_r < IDX_CAP) ? cnt_r + 3'd1 : IDX_CAP;
            end
          endcase
          if (in_data.rx_last) begin
            pos_nxt = 2'd0;
            cnt_nxt = 3'd0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= 2'd0;
      cnt_r     <= 3'd0;
      held_hi_r <= 8'd0;
      held_lo_r <= 8'd0;
    end else begin
      pos_r     <= pos_nxt;
      cnt_r     <= cnt_nxt;
      held_hi_r <= held_hi_nxt;
      held_lo_r <= held_lo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    crc_r <= crc_nxt;
  end

endmodule

FILE: hw/rtl/sfr_queue.sv
module sfr_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sfr_pkg::job_t din,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output sfr_pkg::job_t dout
);

  sfr_pkg::job_t slot_r [sfr_pkg::QDEPTH];
  logic [sfr_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [sfr_pkg::QCNT_W-1:0] cnt_r;
  logic do_push, do_pop;

  assign full    = (cnt_r == sfr_pkg::QCNT_W'(sfr_pkg::QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/sfr_back.sv
module sfr_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  sfr_pkg::job_t      q_dout,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output sfr_pkg::out_item_t out_data
);

  logic               cur_valid_r;
  sfr_pkg::job_t      cur_r;
  logic [2:0]         pos_r;
  logic [7:0]         crc_r;
  logic               out_valid_r;
  sfr_pkg::out_item_t out_data_r;

  logic               adv, emit, load, is_last, crc_feed;
  logic [7:0]         tx_byte;
  sfr_pkg::out_item_t res;

  assign adv   = !out_valid_r || !out_stall;
  assign emit  = cur_valid_r && adv;
  assign load  = (!cur_valid_r || (emit && is_last)) && !q_empty;
  assign q_pop = load;

  always_comb begin
    tx_byte  = crc_r;
    is_last  = 1'b1;
    crc_feed = 1'b0;
    case (cur_r.op)
      sfr_pkg::OP_CMD: begin
        case (pos_r)
          3'd0:    tx_byte = cur_r.word_hi[15:8];
          3'd1:    tx_byte = cur_r.word_hi[7:0];
          default: tx_byte = crc_r;
        endcase
        is_last  = (pos_r == 3'd2);
        crc_feed = (pos_r < 3'd2);
      end
      sfr_pkg::OP_CMD_DATA: begin
        case (pos_r)
          3'd0:    tx_byte = cur_r.word_hi[15:8];
          3'd1:    tx_byte = cur_r.word_hi[7:0];
          3'd2:    tx_byte = cur_r.word_lo[15:8];
          3'd3:    tx_byte = cur_r.word_lo[7:0];
          default: tx_byte = crc_r;
        endcase
        is_last  = (pos_r == 3'd4);
        crc_feed = (pos_r == 3'd2) || (pos_r == 3'd3);
      end
      default: begin
        is_last = 1'b1;
      end
    endcase
  end

  always_comb begin
    res = '0;
    res.last = is_last;
    if (cur_r.op == sfr_pkg::OP_WORD) begin
      res.word_valid     = 1'b1;
      res.word_value     = cur_r.word_hi;
      res.word_index     = cur_r.idx;
      res.crc_ok         = cur_r.crc_ok;
      res.ready_bits_set = cur_r.ready;
    end else begin
      res.tx_valid = 1'b1;
      res.tx_byte  = tx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        cur_valid_r <= 1'b1;
      end else if (emit && is_last) begin
        cur_valid_r <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= q_dout;
      pos_r <= 3'd0;
      crc_r <= sfr_pkg::CRC_INIT;
    end else if (emit) begin
      pos_r <= pos_r + 3'd1;
      if (crc_feed) begin
        crc_r <= sfr_pkg::crc8_byte(crc_r, tx_byte);
      end
    end
    if (emit) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: bench/tb_sensor_word_crc_framer.sv
`timescale 1ns / 100ps

module tb_sensor_word_crc_framer;

  localparam int MAX_RESP_WORDS = 8;
  localparam logic [2:0] IDX_CAP = (MAX_RESP_WORDS - 1 > 7) ? 3'd7 : 3'(MAX_RESP_WORDS - 1);
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int PHASE_ITEMS = 120;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 12;
  localparam int BAD_CRC_PCT = 10;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  sfr_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  sfr_pkg::out_item_t out_data;

  sensor_word_crc_framer #(
    .MAX_RESPONSE_WORDS(MAX_RESP_WORDS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sfr_pkg::in_item_t  pending_transfers[$];
  sfr_pkg::out_item_t predicted_outputs[$];

  // shadow of the deframer state
  logic [1:0] grp_pos = '0;
  logic [7:0] held_hi = '0;
  logic [7:0] held_lo = '0;
  logic [2:0] word_cnt = '0;

  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic in_taken = 1'b0;
  int   stim_count = 0;
  int   in_count = 0;
  int   out_count = 0;
  int   tx_count = 0;
  int   word_count = 0;
  int   bad_crc_count = 0;
  int   capped_count = 0;
  int   fail_count = 0;
  int   cycle_count = 0;

  // bitwise CRC-8 over two bytes, MSB first
  function automatic logic [7:0] pair_crc(input logic [7:0] first, input logic [7:0] second);
    logic [15:0] bits;
    logic [7:0]  c;
    logic        fb;
    bits = {first, second};
    c = sfr_pkg::CRC_INIT;
    for (int i = 15; i >= 0; i--) begin
      fb = c[7] ^ bits[i];
      c = {c[6:0], 1'b0} ^ (fb ? sfr_pkg::CRC_POLY : 8'h00);
    end
    return c;
  endfunction

  function automatic sfr_pkg::out_item_t tx_result(input logic [7:0] b, input logic lst);
    sfr_pkg::out_item_t r;
    r = '0;
    r.tx_valid = 1'b1;
    r.tx_byte = b;
    r.last = lst;
    return r;
  endfunction

  function automatic string fmt_result(input sfr_pkg::out_item_t r);
    return $sformatf("tx=%0d/%02h word=%0d/%04h idx=%0d crc_ok=%0d rdy=%0d last=%0d",
                     r.tx_valid, r.tx_byte, r.word_valid, r.word_value, r.word_index,
                     r.crc_ok, r.ready_bits_set, r.last);
  endfunction

  task automatic frame_or_deframe(input sfr_pkg::in_item_t it);
    sfr_pkg::out_item_t r;
    logic [15:0] w;
    case (it.mode)
      sfr_pkg::MODE_CMD, sfr_pkg::MODE_CMD_DATA: begin
        // a new command always restarts response grouping
        grp_pos = '0;
        word_cnt = '0;
        predicted_outputs.push_back(tx_result(it.command[15:8], 1'b0));
        predicted_outputs.push_back(tx_result(it.command[7:0], 1'b0));
        if (it.mode == sfr_pkg::MODE_CMD) begin
          predicted_outputs.push_back(tx_result(pair_crc(it.command[15:8], it.command[7:0]),
                                                1'b1));
        end else begin
          predicted_outputs.push_back(tx_result(it.data_word[15:8], 1'b0));
          predicted_outputs.push_back(tx_result(it.data_word[7:0], 1'b0));
          predicted_outputs.push_back(tx_result(pair_crc(it.data_word[15:8],
                                                         it.data_word[7:0]), 1'b1));
        end
      end
      sfr_pkg::MODE_RX: begin
        if (grp_pos == 2'd0) begin
          held_hi = it.rx_byte;
          grp_pos = 2'd1;
        end else if (grp_pos == 2'd1) begin
          held_lo = it.rx_byte;
          grp_pos = 2'd2;
        end else begin
          w = {held_hi, held_lo};
          r = '0;
          r.word_valid = 1'b1;
          r.word_value = w;
          r.word_index = (word_cnt > IDX_CAP) ? IDX_CAP : word_cnt;
          r.crc_ok = (pair_crc(held_hi, held_lo) == it.rx_byte);
          r.ready_bits_set = |(w & sfr_pkg::READY_MASK);
          r.last = 1'b1;
          predicted_outputs.push_back(r);
          grp_pos = 2'd0;
          word_cnt = (word_cnt < IDX_CAP) ? word_cnt + 3'd1 : IDX_CAP;
        end
        if (it.rx_last) begin
          grp_pos = '0;
          word_cnt = '0;
        end
      end
      default: ;
    endcase
  endtask

  // driver: new item or idle at the falling edge, hold while stalled
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (pending_transfers.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_data <= pending_transfers.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // monitor: check result transfers, predict on input transfers
  always @(posedge clk) begin : monitor
    sfr_pkg::out_item_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        out_count++;
        if (predicted_outputs.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result transfer: %s", fmt_result(out_data));
        end else begin
          want = predicted_outputs.pop_front();
          if (out_data !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("result %0d mismatch", out_count);
              $display("  expected %s", fmt_result(want));
              $display("  actual   %s", fmt_result(out_data));
            end
          end
          if (want.tx_valid) tx_count++;
          if (want.word_valid) begin
            word_count++;
            if (!want.crc_ok) bad_crc_count++;
            if (want.word_index == IDX_CAP) capped_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        in_count++;
        frame_or_deframe(in_data);
      end
    end
    in_taken <= rst_n && in_valid && !in_stall;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               predicted_outputs.size());
      $display("[sensor_word_crc_framer] ERROR");
      $finish;
    end
  end

  task automatic queue_item(input logic [1:0] m, input logic [15:0] c, input logic [15:0] d,
                            input logic [7:0] b, input logic l);
    sfr_pkg::in_item_t it;
    it.mode = m;
    it.command = c;
    it.data_word = d;
    it.rx_byte = b;
    it.rx_last = l;
    pending_transfers.push_back(it);
    if (m != MODE_UNUSED) stim_count++;
  endtask

  task automatic queue_cmd();
    queue_item(2'($urandom_range(0, 1)), 16'($urandom), 16'($urandom), 8'($urandom),
               1'($urandom));
  endtask

  task automatic queue_rx(input logic [7:0] b, input logic l);
    queue_item(sfr_pkg::MODE_RX, 16'($urandom), 16'($urandom), b, l);
  endtask

  task automatic queue_word(input logic is_final);
    logic [7:0] hi;
    logic [7:0] lo;
    logic [7:0] c;
    hi = 8'($urandom);
    lo = 8'($urandom);
    // some words with the data-ready bits clear
    if ($urandom_range(0, 6) == 0) begin
      hi = hi & 8'hF8;
      lo = 8'h00;
    end
    c = pair_crc(hi, lo);
    if ($urandom_range(0, 99) < BAD_CRC_PCT) c = c ^ (8'h01 << $urandom_range(0, 7));
    queue_rx(hi, 1'b0);
    queue_rx(lo, 1'b0);
    queue_rx(c, is_final);
  endtask

  task automatic fill_random(input int count);
    int start;
    int pick;
    int nwords;
    int nbytes;
    bit closed;
    start = stim_count;
    while (stim_count - start < count) begin
      pick = $urandom_range(0, 99);
      nwords = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 4);
      if (pick < 65) begin
        queue_cmd();
        for (int k = 0; k < nwords; k++) queue_word(k == nwords - 1);
      end else if (pick < 78) begin
        // response cut short: partial triplet, ended by a final byte or a new command
        closed = 1'($urandom_range(0, 1));
        nbytes = $urandom_range(1, 2);
        for (int k = 0; k < nwords - 1; k++) queue_word(1'b0);
        for (int k = 0; k < nbytes; k++) queue_rx(8'($urandom), closed && k == nbytes - 1);
        if (!closed) queue_cmd();
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 6)) queue_rx(8'($urandom), $urandom_range(0, 4) == 0);
      end else if (pick < 96) begin
        queue_cmd();
      end else begin
        queue_item(MODE_UNUSED, 16'($urandom), 16'($urandom), 8'($urandom), 1'($urandom));
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_transfers.size() != 0 || in_valid || predicted_outputs.size() != 0)
      @(posedge clk);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    fill_random(PHASE_ITEMS);
    // sender holds off until everything predicted has come out
    wait_drained();
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    queue_item(sfr_pkg::MODE_CMD, 16'h0000, 16'hFFFF, 8'hFF, 1'b1);
    queue_item(sfr_pkg::MODE_CMD, 16'hFFFF, 16'h0000, 8'h00, 1'b0);
    queue_item(sfr_pkg::MODE_CMD_DATA, 16'h0000, 16'h0000, 8'h00, 1'b0);
    queue_item(sfr_pkg::MODE_CMD_DATA, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
    queue_item(sfr_pkg::MODE_CMD_DATA, 16'h21B1, 16'hBEEF, 8'h5A, 1'b0);
    queue_item(MODE_UNUSED, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
    // good word, then a word with ready bits clear and a corrupted CRC ending the response
    queue_rx(8'hBE, 1'b0);
    queue_rx(8'hEF, 1'b0);
    queue_rx(pair_crc(8'hBE, 8'hEF), 1'b0);
    queue_rx(8'h08, 1'b0);
    queue_rx(8'h00, 1'b0);
    queue_rx(pair_crc(8'h08, 8'h00) ^ 8'h01, 1'b1);
    // partial triplet dropped by the final byte
    queue_rx(8'h12, 1'b0);
    queue_rx(8'h34, 1'b1);
    queue_rx(8'h00, 1'b0);
    queue_rx(8'h00, 1'b0);
    queue_rx(pair_crc(8'h00, 8'h00), 1'b0);
    queue_rx(8'hFF, 1'b0);
    queue_rx(8'hFF, 1'b0);
    queue_rx(pair_crc(8'hFF, 8'hFF), 1'b1);
    // command in the middle of a triplet restarts grouping
    queue_rx(8'hAB, 1'b0);
    queue_item(sfr_pkg::MODE_CMD, 16'h3639, 16'h0000, 8'h00, 1'b0);
    queue_rx(8'h01, 1'b0);
    queue_rx(8'h02, 1'b0);
    queue_rx(pair_crc(8'h01, 8'h02), 1'b1);

    run_phase(0, 0);
    run_phase(78, 0);
    run_phase(0, 78);
    run_phase(31, 31);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d input transfers, %0d result transfers (%0d bytes sent, %0d words)",
             in_count, out_count, tx_count, word_count);
    $display("received words: %0d with a failed CRC, %0d at the saturated index",
             bad_crc_count, capped_count);
    if (fail_count == 0) begin
      $display("[sensor_word_crc_framer] OK");
    end else begin
      $display("%0d failures", fail_count);
      $display("[sensor_word_crc_framer] ERROR");
    end
    $finish;
  end

endmodule
